/* design/assert_macros.svh */
// Assertion macros for the sorter datapath.
// Each macro expects clk and arst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/isort_pkg.sv */
// Shared types for the insertion sorter: beat structs, controller states,
// and the command / status bundles between controller and datapath. No dependencies.
package isort_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_beat_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               end_of_run;
		logic               overflow;
	} result_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_CMP,
		S_OUT_RD,
		S_OUT_LD
	} state_t;

	typedef struct packed {
		logic cap_in;
		logic set_pos;
		logic dec_pos;
		logic rd_scan;
		logic wr_shift;
		logic wr_value;
		logic inc_count;
		logic set_drop;
		logic rd_out;
		logic load_out;
		logic inc_k;
		logic clr_run;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pos_zero;
		logic gt;
		logic last;
		logic k_last;
		logic out_free;
	} sts_t;

endpackage

/* design/isort_ctrl.sv */
// Sequencer for the insertion sorter: walks insertion and readout steps.
// Depends on isort_pkg for state, command and status types.
module isort_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  isort_pkg::sts_t   sts,
	output isort_pkg::cmd_t   cmd
);

	isort_pkg::state_t state_q;
	isort_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isort_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			isort_pkg::S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = isort_pkg::S_START;
				end
			end
			isort_pkg::S_START: begin
				if (sts.full) begin
					cmd.set_drop = 1'b1;
					state_d      = sts.last ? isort_pkg::S_OUT_RD : isort_pkg::S_IDLE;
				end else begin
					cmd.set_pos = 1'b1;
					state_d     = isort_pkg::S_SCAN;
				end
			end
			isort_pkg::S_SCAN: begin
				if (sts.pos_zero) begin
					cmd.wr_value  = 1'b1;
					cmd.inc_count = 1'b1;
					state_d       = sts.last ? isort_pkg::S_OUT_RD : isort_pkg::S_IDLE;
				end else begin
					cmd.rd_scan = 1'b1;
					state_d     = isort_pkg::S_CMP;
				end
			end
			isort_pkg::S_CMP: begin
				if (sts.gt) begin
					cmd.wr_shift = 1'b1;
					cmd.dec_pos  = 1'b1;
					state_d      = isort_pkg::S_SCAN;
				end else begin
					cmd.wr_value  = 1'b1;
					cmd.inc_count = 1'b1;
					state_d       = sts.last ? isort_pkg::S_OUT_RD : isort_pkg::S_IDLE;
				end
			end
			isort_pkg::S_OUT_RD: begin
				cmd.rd_out = 1'b1;
				state_d    = isort_pkg::S_OUT_LD;
			end
			isort_pkg::S_OUT_LD: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.inc_k    = 1'b1;
					if (sts.k_last) begin
						cmd.clr_run = 1'b1;
						state_d     = isort_pkg::S_IDLE;
					end else begin
						state_d = isort_pkg::S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = isort_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* design/isort_dp.sv */
// Datapath for the insertion sorter: sorted store memory, fill count,
// insertion pointer, readout index and result register. Depends on isort_pkg.
`include "assert_macros.svh"

module isort_dp #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isort_pkg::item_beat_t   item,
	input  logic                    result_stall,
	output logic                    result_valid,
	output isort_pkg::result_beat_t result,
	input  isort_pkg::cmd_t         cmd,
	output isort_pkg::sts_t         sts
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic signed [31:0] mem [MAX_ITEMS];

	logic signed [31:0]      value_q;
	logic                    last_q;
	logic signed [31:0]      rdata_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           k_q;
	logic                    drop_q;
	logic                    result_valid_q;
	isort_pkg::result_beat_t result_q;

	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          out_free;

	assign rd_en    = cmd.rd_scan | cmd.rd_out;
	assign rd_addr  = cmd.rd_out ? k_q : (pos_q - AW'(1));
	assign out_free = ~result_valid_q | ~result_stall;

	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[pos_q] <= rdata_q;
		end else if (cmd.wr_value) begin
			mem[pos_q] <= value_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			value_q <= item.value;
			last_q  <= item.last;
		end
		if (cmd.load_out) begin
			result_q.sorted_value <= rdata_q;
			result_q.end_of_run   <= sts.k_last;
			result_q.overflow     <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			pos_q          <= '0;
			k_q            <= '0;
			drop_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.set_pos) begin
				pos_q <= count_q[AW-1:0];
			end else if (cmd.dec_pos) begin
				pos_q <= pos_q - AW'(1);
			end
			if (cmd.clr_run) begin
				count_q <= '0;
				drop_q  <= 1'b0;
				k_q     <= '0;
			end else begin
				if (cmd.inc_count) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.set_drop) begin
					drop_q <= 1'b1;
				end
				if (cmd.inc_k) begin
					k_q <= k_q + AW'(1);
				end
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.full     = (count_q == CW'(MAX_ITEMS));
	assign sts.pos_zero = (pos_q == '0);
	assign sts.gt       = (rdata_q > value_q);
	assign sts.last     = last_q;
	assign sts.k_last   = (CW'(k_q) == count_q - CW'(1));
	assign sts.out_free = out_free;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_ALWAYS(a_count_cap, count_q <= CW'(MAX_ITEMS), "fill count beyond capacity")
	`ASSERT_ALWAYS(a_count_step, (count_q == $past(count_q)) || (count_q == '0) || (count_q == $past(count_q) + CW'(1)), "fill count jumped")
	`ASSERT_IMPLIES(a_wr_in_range, cmd.wr_shift || cmd.wr_value, (CW'(pos_q) <= count_q) && (count_q < CW'(MAX_ITEMS)), "store write outside filled range")

endmodule

/* design/insertion_sorter.sv */
// Insertion sorter: a new beat is accepted only once the last is placed, by scanning down
// the store, shifting up each stored value above it; a beat at a full store is dropped.
// After a run's last beat, readout alternates a read of the sorted store and a result load,
// which waits while a held result is stalled; both use the single read port of the store.
// Reset clears fill count, overflow flag and controller; store contents need no clearing.
module insertion_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  isort_pkg::item_beat_t   item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output isort_pkg::result_beat_t result
);

	isort_pkg::cmd_t cmd;
	isort_pkg::sts_t sts;

	isort_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	isort_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

/* bench/tb_insertion_sorter.sv */
// Testbench for insertion_sorter: drives runs of signed values, predicts each sorted
// readout with an in-bench insertion model and checks every result beat in order.
// Depends on isort_pkg and the insertion_sorter RTL only.
`timescale 1ns / 1ps

module tb_insertion_sorter;

	localparam int SORT_DEPTH = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 260;
	localparam int MAX_SHOWN = 10;

	typedef enum int {
		VALS_FULL,
		VALS_NARROW,
		VALS_EXTREME
	} value_mix_t;

	class sort_scoreboard;
		logic signed [31:0] run_values[$];
		bit run_dropped;
		isort_pkg::result_beat_t pending_results[$];
		int failures;

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_SHOWN)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void note_item(isort_pkg::item_beat_t b);
			logic signed [31:0] v;
			int pos;
			isort_pkg::result_beat_t r;
			v = b.value;
			if (run_values.size() < SORT_DEPTH) begin
				pos = run_values.size();
				while (pos > 0 && run_values[pos - 1] > v)
					pos--;
				run_values.insert(pos, v);
			end else begin
				run_dropped = 1'b1;
			end
			if (b.last) begin
				foreach (run_values[k]) begin
					r.sorted_value = run_values[k];
					r.end_of_run = (k == run_values.size() - 1);
					r.overflow = run_dropped;
					pending_results.insert(pending_results.size(), r);
				end
				run_values.delete();
				run_dropped = 1'b0;
			end
		endfunction

		function void check_result(isort_pkg::result_beat_t got);
			isort_pkg::result_beat_t want;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result beat with none pending: value %0d end %0b ovf %0b",
					got.sorted_value, got.end_of_run, got.overflow));
				return;
			end
			want = pending_results.pop_front();
			if (got.sorted_value !== want.sorted_value || got.end_of_run !== want.end_of_run
					|| got.overflow !== want.overflow)
				note_failure($sformatf("want value %0d end %0b ovf %0b, got value %0d end %0b ovf %0b",
					want.sorted_value, want.end_of_run, want.overflow,
					got.sorted_value, got.end_of_run, got.overflow));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	isort_pkg::item_beat_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	isort_pkg::result_beat_t result;

	sort_scoreboard sb = new();
	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_phase_left = 0;

	insertion_sorter #(
		.MAX_ITEMS(SORT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: phases of no stall, light, heavy and coin-flip stalling
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_phase_left = $urandom_range(10, 80);
		end else begin
			stall_phase_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 7) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// called right after a rising edge; returns at the edge that takes the beat
	task automatic send_item(input logic signed [31:0] v, input logic is_last);
		isort_pkg::item_beat_t b;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		b.value = v;
		b.last = is_last;
		item <= b;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	function automatic logic signed [31:0] pick_value(value_mix_t mix);
		logic signed [31:0] v;
		case (mix)
			VALS_NARROW: v = $signed($urandom_range(0, 8)) - 4;
			VALS_EXTREME: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh7FFF_FFFF;
					1: v = 32'sh8000_0000;
					2: v = '0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_run(input int len, input value_mix_t mix);
		for (int i = 0; i < len; i++)
			send_item(pick_value(mix), i == len - 1);
	endtask

	initial begin
		logic signed [31:0] mixed_run[$];
		int run_no;
		int run_len;
		mixed_run = '{0, -1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 5, 5, -5};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-beat runs at both extremes
		send_item(32'sh7FFF_FFFF, 1'b1);
		send_item(32'sh8000_0000, 1'b1);
		// extremes, duplicates and signs in one run
		foreach (mixed_run[i])
			send_item(mixed_run[i], i == mixed_run.size() - 1);
		// descending runs, positive then negative, force the longest shifts
		for (int i = 6; i >= 1; i--)
			send_item(i, i == 1);
		for (int i = 1; i <= 5; i++)
			send_item(-i * 1000, i == 5);

		run_no = 0;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (run_no == 3)
				run_len = SORT_DEPTH;
			else if (run_no == 7 || run_no == 12)
				run_len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
			else if ($urandom_range(0, 9) == 0)
				run_len = $urandom_range(16, 40);
			else
				run_len = $urandom_range(1, 12);
			send_run(run_len, value_mix_t'($urandom_range(0, 2)));
			run_no++;
		end
		item_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.note_failure("results still pending at end of run");
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/isort_pkg.sv
design/isort_ctrl.sv
design/isort_dp.sv
design/insertion_sorter.sv
bench/tb_insertion_sorter.sv
